### hdl/aes_pkg.sv
// AES-128 encryption package: S-box table, key store sizes and round functions.
package aes_pkg;

  // Round key store geometry
  localparam int KEY_ADDR_W = 4;
  localparam int KEY_DEPTH  = 11;
  localparam int BLOCK_W    = 128;

  localparam logic [KEY_ADDR_W-1:0] KEY_COUNT  = 4'd11;
  localparam logic [KEY_ADDR_W-1:0] LAST_ROUND = 4'd10;

  // Request codes
  typedef enum logic {
    REQ_LOAD_KEY = 1'b0,
    REQ_ENCRYPT  = 1'b1
  } req_type_t;

  // Forward S-box
  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and optional MixColumns; byte 0 is the top byte
  function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] s,
                                                    input logic mix);
    logic [7:0] sb [16];
    logic [7:0] t  [16];
    logic [7:0] a0, a1, a2, a3;
    logic [BLOCK_W-1:0] res;
    for (int i = 0; i < 16; i++) begin
      sb[i] = s[BLOCK_W-1-8*i -: 8];
    end
    // byte row + 4*col is row, col
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        t[row + 4*col] = SBOX[sb[row + 4*((col + row) % 4)]];
      end
    end
    res = '0;
    for (int col = 0; col < 4; col++) begin
      a0 = t[4*col];
      a1 = t[4*col + 1];
      a2 = t[4*col + 2];
      a3 = t[4*col + 3];
      if (mix) begin
        res[BLOCK_W-1-8*(4*col)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        res[BLOCK_W-1-8*(4*col+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        res[BLOCK_W-1-8*(4*col+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        res[BLOCK_W-1-8*(4*col+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end else begin
        res[BLOCK_W-1-8*(4*col)   -: 8] = a0;
        res[BLOCK_W-1-8*(4*col+1) -: 8] = a1;
        res[BLOCK_W-1-8*(4*col+2) -: 8] = a2;
        res[BLOCK_W-1-8*(4*col+3) -: 8] = a3;
      end
    end
    return res;
  endfunction

endpackage

### hdl/aes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/aes128_block_encrypt.sv
// AES-128 block encryption engine with a RAM of preloaded round keys.
//
// Request channel (req_valid / req_stall): req_type selects a round key load
// or a block encryption. A load writes data_hi:data_lo into key slot
// round_index (slots 11 to 15 are dropped) and returns nothing. An encrypt
// runs the full cipher on data_hi:data_lo using keys 0 to 10, which must all
// have been loaded first.
// Result channel (res_valid / res_stall): one ciphertext per encrypt, held in
// an output register until taken.
// Timing: a load writes the key RAM on its accept. An encrypt runs one round per
// cycle out of the key RAM (initial key add plus ten rounds); the result is valid
// on the cycle after the last round. The next request is taken while the previous
// result still waits in the output register.
// If the result register is still occupied when a block finishes, the engine
// holds the finished block and keeps req_stall high until the register frees.
// Reset returns the engine to idle and empties the result register; the key
// RAM keeps whatever it held and must be reloaded.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [0:0]  req_type,
  input  logic [3:0]  round_index,
  input  logic [63:0] data_hi,
  input  logic [63:0] data_lo,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] cipher_hi,
  output logic [63:0] cipher_lo
);

  import aes_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } phase_t;

  phase_t                  phase;
  logic [KEY_ADDR_W-1:0]   rnd;
  logic [BLOCK_W-1:0]      st;

  logic                    accept;
  logic                    key_we;
  logic [KEY_ADDR_W-1:0]   key_raddr;
  logic [BLOCK_W-1:0]      key;
  logic [BLOCK_W-1:0]      st_next;
  logic                    out_free;
  logic                    res_load;

  // Round key store
  aes_ram #(
    .WIDTH(BLOCK_W),
    .DEPTH(KEY_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(round_index),
    .wdata({data_hi, data_lo}),
    .raddr(key_raddr),
    .rdata(key)
  );

  // Handshake and key RAM control
  always_comb begin
    req_stall = (phase != IDLE);
    accept    = req_valid && !req_stall;
    key_we    = accept && (req_type == REQ_LOAD_KEY) && (round_index < KEY_COUNT);
    out_free  = !res_valid || !res_stall;
    // a finished block moves into the result register
    res_load  = out_free && ((phase == RUN && rnd == LAST_ROUND) || phase == DRAIN);
    // prefetch the key for the next round
    if (phase == RUN && rnd != LAST_ROUND) begin
      key_raddr = KEY_ADDR_W'(rnd + 4'd1);
    end else begin
      key_raddr = '0;
    end
  end

  // One round per cycle; round zero is the plain key add
  always_comb begin
    if (rnd == '0) begin
      st_next = st ^ key;
    end else begin
      st_next = enc_round(st, rnd != LAST_ROUND) ^ key;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= IDLE;
      rnd       <= '0;
      res_valid <= 1'b0;
    end else begin
      // result valid: set by a finished block, cleared when taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (phase)
        IDLE: begin
          if (accept && req_type == REQ_ENCRYPT) begin
            st    <= {data_hi, data_lo};
            rnd   <= '0;
            phase <= RUN;
          end
        end
        RUN: begin
          st <= st_next;
          if (rnd == LAST_ROUND) begin
            if (out_free) begin
              {cipher_hi, cipher_lo} <= st_next;
              phase                  <= IDLE;
            end else begin
              phase <= DRAIN;
            end
          end else begin
            rnd <= KEY_ADDR_W'(rnd + 4'd1);
          end
        end
        DRAIN: begin
          if (out_free) begin
            {cipher_hi, cipher_lo} <= st;
            phase                  <= IDLE;
          end
        end
        default: begin
          phase <= IDLE;
        end
      endcase
    end
  end

endmodule

### dv/aes128_cipher_monitor.sv
`timescale 1ns / 1ps
// Monitor for the AES-128 engine: watches both channels, predicts ciphertexts, compares.
module aes128_cipher_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [0:0]  req_type,
  input  logic [3:0]  round_index,
  input  logic [63:0] data_hi,
  input  logic [63:0] data_lo,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [63:0] cipher_hi,
  input  logic [63:0] cipher_lo,
  output int          errors,
  output int          pending,
  output int          blocks_seen,
  output int          keys_loaded
);
  import aes_pkg::*;

  logic [7:0]   sbox_tbl [256];
  logic [127:0] key_copy [KEY_DEPTH];
  logic [127:0] cipher_q [$];

  int err_cnt   = 0;
  int open_cnt  = 0;
  int block_cnt = 0;
  int load_cnt  = 0;

  assign errors      = err_cnt;
  assign pending     = open_cnt;
  assign blocks_seen = block_cnt;
  assign keys_loaded = load_cnt;

  // GF(2^8) multiply, AES polynomial
  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box entry: inverse as x^254 (zero maps to zero), then the affine map
  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq  = x;
    for (int i = 1; i < 8; i++) begin
      sq  = gf_mult(sq, sq);
      inv = gf_mult(inv, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
           {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Full cipher on one block with the mirrored key store
  function automatic logic [127:0] cipher_of(input logic [127:0] pt);
    logic [7:0]   st [16];
    logic [7:0]   sh [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] blk;
    blk = pt ^ key_copy[0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
      // byte r + 4c is row r, column c; row r rotates left by r
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          sh[r + 4*c] = sbox_tbl[st[r + 4*((c + r) & 3)]];
        end
      end
      for (int c = 0; c < 4; c++) begin
        a0 = sh[4*c];
        a1 = sh[4*c + 1];
        a2 = sh[4*c + 2];
        a3 = sh[4*c + 3];
        if (rnd < 10) begin
          st[4*c]     = gf_mult(a0, 8'h02) ^ gf_mult(a1, 8'h03) ^ a2 ^ a3;
          st[4*c + 1] = a0 ^ gf_mult(a1, 8'h02) ^ gf_mult(a2, 8'h03) ^ a3;
          st[4*c + 2] = a0 ^ a1 ^ gf_mult(a2, 8'h02) ^ gf_mult(a3, 8'h03);
          st[4*c + 3] = gf_mult(a0, 8'h03) ^ a1 ^ a2 ^ gf_mult(a3, 8'h02);
        end else begin
          st[4*c]     = a0;
          st[4*c + 1] = a1;
          st[4*c + 2] = a2;
          st[4*c + 3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = st[i];
      blk = blk ^ key_copy[rnd];
    end
    return blk;
  endfunction

  initial begin
    for (int x = 0; x < 256; x++) sbox_tbl[x] = sbox_calc(8'(x));
  end

  // Track accepted requests and check accepted results in order
  always @(posedge clk) begin : watch
    logic [127:0] want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        if (req_type == REQ_ENCRYPT) begin
          cipher_q.push_back(cipher_of({data_hi, data_lo}));
        end else if (round_index < KEY_COUNT) begin
          key_copy[round_index] = {data_hi, data_lo};
          load_cnt++;
        end
      end
      if (res_valid && !res_stall) begin
        if (cipher_q.size() == 0) begin
          err_cnt++;
          $display("%0t: expected no result, got %h_%h", $time, cipher_hi, cipher_lo);
        end else begin
          want = cipher_q.pop_front();
          block_cnt++;
          if (cipher_hi !== want[127:64]) begin
            err_cnt++;
            $display("%0t: cipher_hi expected %h, got %h", $time, want[127:64], cipher_hi);
          end
          if (cipher_lo !== want[63:0]) begin
            err_cnt++;
            $display("%0t: cipher_lo expected %h, got %h", $time, want[63:0], cipher_lo);
          end
        end
      end
      open_cnt = cipher_q.size();
    end
  end

endmodule

### dv/aes128_block_encrypt_tb.sv
`timescale 1ns / 1ps
// Testbench top for the AES-128 engine: reset, request stimulus, result stalls, verdict.
module aes128_block_encrypt_tb;
  import aes_pkg::*;

  // Known expanded schedule for key 2b7e1516_28aed2a6_abf71588_09cf4f3c
  localparam logic [127:0] SAMPLE_SCHEDULE [11] = '{
    128'h2b7e151628aed2a6abf7158809cf4f3c, 128'ha0fafe1788542cb123a339392a6c7605,
    128'hf2c295f27a96b9435935807a7359f67f, 128'h3d80477d4716fe3e1e237e446d7a883b,
    128'hef44a541a8525b7fb671253bdb0bad00, 128'hd4d1c6f87c839d87caf2b8bc11f915bc,
    128'h6d88a37a110b3efddbf98641ca0093fd, 128'h4e54f70e5f5fc9f384a64fb24ea6dc4f,
    128'head27321b58dbad2312bf5607f8d292f, 128'hac7766f319fadc2128d12941575c006e,
    128'hd014f9a8c9ee2589e13f0cc8b6630ca6
  };
  localparam int IDLE_PCT  [4] = '{0, 72, 0, 23};
  localparam int STALL_PCT [4] = '{0, 0, 72, 23};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [0:0]  req_type = REQ_LOAD_KEY;
  logic [3:0]  round_index = '0;
  logic [63:0] data_hi = '0;
  logic [63:0] data_lo = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;

  int idle_pct  = 0;
  int stall_pct = 0;
  int fail_cnt, open_cnt, cipher_cnt, key_cnt;

  always #5 clk = ~clk;

  aes128_block_encrypt dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .round_index (round_index),
    .data_hi     (data_hi),
    .data_lo     (data_lo),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .cipher_hi   (cipher_hi),
    .cipher_lo   (cipher_lo)
  );

  aes128_cipher_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .round_index (round_index),
    .data_hi     (data_hi),
    .data_lo     (data_lo),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .cipher_hi   (cipher_hi),
    .cipher_lo   (cipher_lo),
    .errors      (fail_cnt),
    .pending     (open_cnt),
    .blocks_seen (cipher_cnt),
    .keys_loaded (key_cnt)
  );

  // Result side back-pressure
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // One request, with random idle cycles ahead of it
  task automatic send_req(input req_type_t kind, input logic [3:0] slot,
                          input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= kind;
    round_index <= slot;
    data_hi     <= hi;
    data_lo     <= lo;
    do @(posedge clk); while (req_stall);
  endtask

  // Mostly encrypts; some key reloads over all 16 slot codes
  task automatic random_req();
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    slot = 4'($urandom_range(15));
    hi   = {$urandom, $urandom};
    lo   = {$urandom, $urandom};
    case ($urandom_range(19))
      0, 1, 2: send_req(REQ_LOAD_KEY, slot, hi, lo);
      3:       send_req(REQ_ENCRYPT, slot, hi & {$urandom, $urandom}, lo | {$urandom, $urandom});
      default: send_req(REQ_ENCRYPT, slot, hi, lo);
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: full schedule first, so no encrypt reads an unwritten key
    for (int i = 0; i < 11; i++) begin
      send_req(REQ_LOAD_KEY, 4'(i), SAMPLE_SCHEDULE[i][127:64], SAMPLE_SCHEDULE[i][63:0]);
    end
    // out-of-range slots must be dropped
    send_req(REQ_LOAD_KEY, 4'd11, '1, '1);
    send_req(REQ_LOAD_KEY, 4'd15, 64'hdeadbeef_01234567, '0);
    // slot field is ignored on encrypt
    send_req(REQ_ENCRYPT, 4'd15, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_req(REQ_ENCRYPT, 4'd0, '0, '0);
    send_req(REQ_ENCRYPT, 4'd10, '1, '1);
    send_req(REQ_ENCRYPT, 4'd7, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    // extreme key values at both ends of the schedule
    send_req(REQ_LOAD_KEY, 4'd0, '0, '0);
    send_req(REQ_LOAD_KEY, 4'd10, '1, '1);
    send_req(REQ_ENCRYPT, 4'd0, '1, '0);
    send_req(REQ_ENCRYPT, 4'd12, '0, '1);

    // Random traffic over four idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      repeat (200) random_req();
    end
    req_valid <= 1'b0;

    // Drain, then allow for a late stray result
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d in-range key loads and %0d checked ciphertexts", key_cnt, cipher_cnt);
    $display("across idle-free, sender-idle, receiver-stall and mixed phases");
    if (fail_cnt == 0) begin
      $display("aes128_block_encrypt_tb OK");
    end else begin
      $display("aes128_block_encrypt_tb NOT OK");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", open_cnt);
    $display("aes128_block_encrypt_tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes128_block_encrypt.sv
dv/aes128_cipher_monitor.sv
dv/aes128_block_encrypt_tb.sv
